// ===== hdl/spq_pkg.sv =====
// Types and constants shared by the sorted priority queue and its testbench.
package spq_pkg;

  // Field widths of a request and of a stored entry.
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Request codes; the unused code is served as a top request.
  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TOP  = 2'd2;

  // Status codes returned with every result.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

  // One stored entry, packed as {priority, id, age}.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
  } spq_entry_t;

  localparam int unsigned ENTRY_W = $bits(spq_entry_t);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_PUSH_INS,
    ST_POP_RD,
    ST_POP_WR,
    ST_HEAD_RD,
    ST_HEAD_OUT
  } spq_state_e;

endpackage

// ===== hdl/spq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue: a bounded list in RAM kept highest priority first.
//
//   Channel   Direction  Handshake                    Payload
//   request   in         start_i high, busy_o low     req_type_i, entry_priority_i,
//                                                     entry_id_i, entry_age_i
//   result    out        done_o, one cycle, no stall  head_valid_o, head_priority_o,
//                                                     head_id_o, head_age_o,
//                                                     entry_count_o, status_o
//
// One request is served at a time, and the receiver cannot stall. A top request, a push to
// a full queue or a pop on an empty queue only reads the head. A push moves entries down
// until it stops behind a higher entry or becomes the head; a pop moves every entry behind
// the head up one slot. Each moved entry costs one RAM read and one RAM write. done_o rises
// in the cycle that busy_o falls, and a new request may be transferred in that same cycle.
// Reset empties the queue; the RAM is not cleared.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [PRIO_W-1:0]   entry_priority_i,
  input  logic [ID_W-1:0]     entry_id_i,
  input  logic [AGE_W-1:0]    entry_age_i,
  output logic                done_o,
  output logic                head_valid_o,
  output logic [PRIO_W-1:0]   head_priority_o,
  output logic [ID_W-1:0]     head_id_o,
  output logic [AGE_W-1:0]    head_age_o,
  output logic [COUNT_W-1:0]  entry_count_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Control state.
  spq_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q, done_d;

  // Latched request payload and status.
  spq_entry_t          new_q, new_d;
  logic [STATUS_W-1:0] status_q, status_d;

  // Result registers.
  spq_entry_t       head_q, head_d;
  logic             head_valid_q, head_valid_d;
  logic [CNT_W-1:0] out_count_q, out_count_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  // RAM port signals.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  spq_entry_t       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  spq_entry_t       rd_entry;

  // Count and compare helpers.
  logic [CNT_W-1:0]   count_last;
  logic               stored_gt_new;
  logic [CNT_W+4:0]   count_ext;

  assign rd_entry   = spq_entry_t'(ram_rdata);
  assign count_last = count_q - CNT_W'(1);

  // The push comparator: does the stored entry outrank the new one?
  assign stored_gt_new = rd_entry.prio > new_q.prio;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Payload and result registers.
  always_ff @(posedge clk_i) begin
    new_q        <= new_d;
    status_q     <= status_d;
    head_q       <= head_d;
    head_valid_q <= head_valid_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  // Sequencer: next state, RAM accesses and result capture.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    done_d       = 1'b0;
    new_d        = new_q;
    status_d     = status_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q + IDX_W'(1);
    ram_wdata    = rd_entry;
    ram_raddr    = idx_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          new_d.prio = entry_priority_i;
          new_d.id   = entry_id_i;
          new_d.age  = entry_age_i;
          status_d   = STATUS_OK;
          state_d    = ST_HEAD_RD;
          case (req_type_i)
            REQ_PUSH: begin
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                status_d = STATUS_PUSH_FULL;
              end else if (count_q == '0) begin
                state_d = ST_PUSH_INS;
              end else begin
                // Scan from the tail toward the head.
                idx_d   = count_last[IDX_W-1:0];
                state_d = ST_PUSH_RD;
              end
            end
            REQ_POP: begin
              if (count_q == '0) begin
                status_d = STATUS_POP_EMPTY;
              end else if (count_q == CNT_W'(1)) begin
                count_d = '0;
              end else begin
                idx_d   = IDX_W'(1);
                state_d = ST_POP_RD;
              end
            end
            default: begin
              state_d = ST_HEAD_RD;
            end
          endcase
        end
      end

      ST_PUSH_RD: begin
        state_d = ST_PUSH_CMP;
      end

      // Either the new entry lands behind this one, or this one moves down.
      ST_PUSH_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q + IDX_W'(1);
        if (stored_gt_new) begin
          ram_wdata = new_q;
          count_d   = count_q + CNT_W'(1);
          state_d   = ST_HEAD_RD;
        end else begin
          ram_wdata = rd_entry;
          if (idx_q == '0) begin
            state_d = ST_PUSH_INS;
          end else begin
            idx_d   = idx_q - IDX_W'(1);
            state_d = ST_PUSH_RD;
          end
        end
      end

      // The new entry becomes the head.
      ST_PUSH_INS: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_q;
        count_d   = count_q + CNT_W'(1);
        state_d   = ST_HEAD_RD;
      end

      ST_POP_RD: begin
        state_d = ST_POP_WR;
      end

      // Move each entry one slot toward the head.
      ST_POP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q - IDX_W'(1);
        ram_wdata = rd_entry;
        if (CNT_W'(idx_q) == count_last) begin
          count_d = count_last;
          state_d = ST_HEAD_RD;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_POP_RD;
        end
      end

      ST_HEAD_RD: begin
        ram_raddr = '0;
        state_d   = ST_HEAD_OUT;
      end

      // Capture the head; an empty queue reports zeros.
      ST_HEAD_OUT: begin
        head_valid_d = count_q != '0;
        head_d       = (count_q != '0) ? rd_entry : '0;
        out_count_d  = count_q;
        out_status_d = status_q;
        done_d       = 1'b1;
        state_d      = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The count output keeps only its low bits.
  assign count_ext = {5'b0, out_count_q};

  assign busy_o          = state_q != ST_IDLE;
  assign done_o          = done_q;
  assign head_valid_o    = head_valid_q;
  assign head_priority_o = head_q.prio;
  assign head_id_o       = head_q.id;
  assign head_age_o      = head_q.age;
  assign entry_count_o   = count_ext[COUNT_W-1:0];
  assign status_o        = out_status_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sorted priority queue, with directed and random requests.
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam time         HALF_PERIOD  = 6ns;
  localparam int unsigned RESET_CYCLES = 7;
  // The longest push moves every stored entry; the wait is sized from the depth, plus slack.
  localparam int unsigned DRAIN_CYCLES = 2 * QUEUE_DEPTH + 16;
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned NUM_DIRECTED = 25;
  localparam int unsigned NUM_PHASES   = 3;
  localparam int unsigned NUM_BURSTS   = 9;
  localparam int unsigned BURST_LEN    = 40;

  // The unused request code is served as a top request.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Head, count and status returned with every transfer.
  typedef struct packed {
    logic                valid;
    logic [PRIO_W-1:0]   prio;
    logic [ID_W-1:0]     id;
    logic [AGE_W-1:0]    age;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } head_t;

  // One directed request; typed marks a row whose expected head is given here.
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
    logic              typed;
    head_t             head;
  } stim_row_t;

  localparam head_t NO_HEAD = '{1'b0, 8'h00, 16'h0000, 8'h00, 5'd0, STATUS_OK};

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{REQ_TOP,    8'h00, 16'h0000, 8'h00, 1'b1, NO_HEAD},
    '{REQ_POP,    8'h5A, 16'hA5A5, 8'h3C, 1'b1,
      '{1'b0, 8'h00, 16'h0000, 8'h00, 5'd0, STATUS_POP_EMPTY}},
    '{REQ_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, NO_HEAD},
    '{REQ_PUSH,   8'h00, 16'h0000, 8'h00, 1'b1,
      '{1'b1, 8'h00, 16'h0000, 8'h00, 5'd1, STATUS_OK}},
    '{REQ_PUSH,   8'hFF, 16'hFFFF, 8'hFF, 1'b1,
      '{1'b1, 8'hFF, 16'hFFFF, 8'hFF, 5'd2, STATUS_OK}},
    '{REQ_PUSH,   8'hFF, 16'h1234, 8'h5A, 1'b1,
      '{1'b1, 8'hFF, 16'h1234, 8'h5A, 5'd3, STATUS_OK}},
    '{REQ_PUSH,   8'h00, 16'hBEEF, 8'h01, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'h80, 16'h5555, 8'hAA, 1'b0, NO_HEAD},
    '{REQ_TOP,    8'h12, 16'h3456, 8'h78, 1'b0, NO_HEAD},
    '{REQ_UNUSED, 8'h00, 16'h0000, 8'h00, 1'b0, NO_HEAD},
    '{REQ_POP,    8'hFF, 16'hFFFF, 8'hFF, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'h7F, 16'h0001, 8'h10, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'h81, 16'h0002, 8'h20, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'h80, 16'h0003, 8'h30, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'h01, 16'h8000, 8'h80, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'hFE, 16'h7FFF, 8'h7F, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'h80, 16'hC3C3, 8'hC3, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'h00, 16'h0F0F, 8'hF0, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'h40, 16'h00FF, 8'h0F, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'hC0, 16'hFF00, 8'h55, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'h80, 16'h6666, 8'h66, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'h10, 16'h9999, 8'h99, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'hF0, 16'hABCD, 8'hEF, 1'b0, NO_HEAD},
    '{REQ_PUSH,   8'hFF, 16'hDEAD, 8'hAD, 1'b0, NO_HEAD},
    '{REQ_POP,    8'h33, 16'h3333, 8'h33, 1'b0, NO_HEAD}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [REQ_W-1:0]    req_type_i;
  logic [PRIO_W-1:0]   entry_priority_i;
  logic [ID_W-1:0]     entry_id_i;
  logic [AGE_W-1:0]    entry_age_i;
  logic                done_o;
  logic                head_valid_o;
  logic [PRIO_W-1:0]   head_priority_o;
  logic [ID_W-1:0]     head_id_o;
  logic [AGE_W-1:0]    head_age_o;
  logic [COUNT_W-1:0]  entry_count_o;
  logic [STATUS_W-1:0] status_o;

  // Typed expectation travelling with the request that carries it.
  logic  typed_check;
  head_t typed_head;

  spq_entry_t  held_entries [$];
  head_t       pending_heads [$];
  int unsigned sender_idle_pct;
  int unsigned fail_count;
  int unsigned results_checked;
  int unsigned push_count, push_full_count, pop_count, pop_empty_count, top_count;

  sorted_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_type_i      (req_type_i),
    .entry_priority_i(entry_priority_i),
    .entry_id_i      (entry_id_i),
    .entry_age_i     (entry_age_i),
    .done_o          (done_o),
    .head_valid_o    (head_valid_o),
    .head_priority_o (head_priority_o),
    .head_id_o       (head_id_o),
    .head_age_o      (head_age_o),
    .entry_count_o   (entry_count_o),
    .status_o        (status_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Applies one request to the sorted list kept here and returns the new head.
  function automatic head_t apply_request(input logic [REQ_W-1:0] req, input spq_entry_t e);
    head_t       h;
    int unsigned pos;
    h = '0;
    h.status = STATUS_OK;
    if (req == REQ_PUSH) begin
      if (held_entries.size() >= QUEUE_DEPTH) begin
        h.status = STATUS_PUSH_FULL;
      end else begin
        // Insert ahead of the first entry whose priority is not higher.
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio > e.prio) pos++;
        held_entries.insert(pos, e);
      end
    end else if (req == REQ_POP) begin
      if (held_entries.size() == 0) begin
        h.status = STATUS_POP_EMPTY;
      end else begin
        void'(held_entries.pop_front());
      end
    end
    if (held_entries.size() != 0) begin
      h.valid = 1'b1;
      h.prio  = held_entries[0].prio;
      h.id    = held_entries[0].id;
      h.age   = held_entries[0].age;
    end
    h.count = COUNT_W'(held_entries.size());
    return h;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result checking first, then prediction for a request transferred at this edge.
  always @(posedge clk_i) begin
    head_t      want;
    spq_entry_t e;
    if (rst_ni && done_o) begin
      if (pending_heads.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        fail_count++;
      end else begin
        want = pending_heads.pop_front();
        compare_field("head_valid", 32'(want.valid), 32'(head_valid_o));
        compare_field("head_priority", 32'(want.prio), 32'(head_priority_o));
        compare_field("head_id", 32'(want.id), 32'(head_id_o));
        compare_field("head_age", 32'(want.age), 32'(head_age_o));
        compare_field("entry_count", 32'(want.count), 32'(entry_count_o));
        compare_field("status", 32'(want.status), 32'(status_o));
        results_checked++;
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      e.prio = entry_priority_i;
      e.id   = entry_id_i;
      e.age  = entry_age_i;
      want = apply_request(req_type_i, e);
      case (req_type_i)
        REQ_PUSH: begin
          push_count++;
          if (want.status == STATUS_PUSH_FULL) push_full_count++;
        end
        REQ_POP: begin
          pop_count++;
          if (want.status == STATUS_POP_EMPTY) pop_empty_count++;
        end
        default: top_count++;
      endcase
      pending_heads.push_back(typed_check ? typed_head : want);
    end
  end

  // Presents one request after a random pause and holds it until the transfer.
  // Called right after a falling edge, and returns right after one.
  task automatic issue(input logic [REQ_W-1:0] req, input logic [PRIO_W-1:0] prio,
                       input logic [ID_W-1:0] id, input logic [AGE_W-1:0] age,
                       input logic typed, input head_t head);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i          <= 1'b1;
    req_type_i       <= req;
    entry_priority_i <= prio;
    entry_id_i       <= id;
    entry_age_i      <= age;
    typed_check      <= typed;
    typed_head       <= head;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Random request; push_pct steers the queue toward full or empty, and
  // a narrow priority set makes ties common.
  task automatic issue_random(input int unsigned push_pct, input bit narrow);
    logic [REQ_W-1:0]  req;
    logic [PRIO_W-1:0] prio;
    int unsigned       roll;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      req = REQ_PUSH;
    end else if ($urandom_range(3) != 0) begin
      req = REQ_POP;
    end else begin
      req = ($urandom_range(3) == 0) ? REQ_UNUSED : REQ_TOP;
    end
    if (narrow) begin
      prio = PRIO_W'($urandom_range(3) * 85);
    end else if ($urandom_range(9) == 0) begin
      prio = $urandom_range(1) ? 8'hFF : 8'h00;
    end else begin
      prio = PRIO_W'($urandom_range(255));
    end
    issue(req, prio, ID_W'($urandom), AGE_W'($urandom), 1'b0, NO_HEAD);
  endtask

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("Run timed out with %0d results outstanding", pending_heads.size());
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence: reset, directed table, three random phases, then drain.
  initial begin
    int unsigned waited;
    int unsigned phase_idle [NUM_PHASES];
    phase_idle = '{38, 46, 0};
    fail_count = 0;
    results_checked = 0;
    push_count = 0;
    push_full_count = 0;
    pop_count = 0;
    pop_empty_count = 0;
    top_count = 0;
    sender_idle_pct = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_type_i = REQ_TOP;
    entry_priority_i = '0;
    entry_id_i = '0;
    entry_age_i = '0;
    typed_check = 1'b0;
    typed_head = NO_HEAD;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows run with the first phase's sender pauses.
    sender_idle_pct = phase_idle[0];
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      issue(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].prio, DIRECTED_ROWS[r].id,
            DIRECTED_ROWS[r].age, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].head);
    end

    // Random bursts, each biased to fill, drain or hover.
    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_idle_pct = phase_idle[p];
      for (int b = 0; b < NUM_BURSTS; b++) begin
        int unsigned push_pct;
        bit          narrow;
        case ($urandom_range(2))
          0:       push_pct = 80;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
        narrow = 1'($urandom_range(1));
        for (int k = 0; k < BURST_LEN; k++) issue_random(push_pct, narrow);
      end
    end
    start_i <= 1'b0;

    // Wait for every outstanding result, then watch for strays.
    waited = 0;
    while (pending_heads.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_heads.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_heads.size());
      fail_count++;
    end

    $display("Checked %0d results: %0d pushes (%0d dropped on full), %0d pops",
             results_checked, push_count, push_full_count, pop_count);
    $display("(%0d on empty), %0d head reads; %0d mismatches or protocol errors.",
             pop_empty_count, top_count, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
